@@ src/ring_queue_with_window_mean_unit_defines.svh @@
// Assertion macros shared by the ring queue design.
`ifndef RING_QUEUE_WITH_WINDOW_MEAN_UNIT_DEFINES_SVH
`define RING_QUEUE_WITH_WINDOW_MEAN_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RQWM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define RQWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/rqwm_pkg.sv @@
`timescale 1ns / 1ps

package rqwm_pkg;

  localparam int SLOTS_DEF   = 6;
  localparam int ID_BITS_DEF = 12;
  localparam int ID_W        = 12;
  localparam int HEIGHT_W    = 8;
  localparam int OCC_W       = 3;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [ID_W-1:0]     player_id;
    logic [HEIGHT_W-1:0] height;
  } req_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] mean_height;
    logic [ID_W-1:0]     removed_id;
    logic [HEIGHT_W-1:0] removed_height;
    logic                empty_error;
    logic [OCC_W-1:0]    occupancy;
  } result_t;

endpackage

@@ src/ring_queue_with_window_mean_unit.sv @@
// An insert passes the read, divide and round states before its result; a remove gives it from the read state.
// Transactions do not overlap: start is taken only while idle, and busy is high until done.
// The insert time is set by the bit-serial divider, one quotient bit per cycle, plus rounding.
// The result strobe done lasts one cycle; the receiver cannot stall.
// A synchronous reset empties the queue; the entry memory itself is not cleared.
`timescale 1ns / 1ps
`include "ring_queue_with_window_mean_unit_defines.svh"

module ring_queue_with_window_mean_unit #(
  parameter int SLOTS   = rqwm_pkg::SLOTS_DEF,
  parameter int ID_BITS = rqwm_pkg::ID_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  rqwm_pkg::req_t    req,
  output logic              busy,
  output logic              done,
  output rqwm_pkg::result_t result
);
  import rqwm_pkg::*;

  localparam int IDXW  = $clog2(SLOTS);
  localparam int SUMW  = HEIGHT_W + IDXW;
  localparam int ENTW  = ID_BITS + HEIGHT_W;
  localparam int STEPW = $clog2(HEIGHT_W);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_DIV   = 4'b0100,
    S_ROUND = 4'b1000
  } state_t;

  state_t              state;
  logic [IDXW-1:0]     head;
  logic [IDXW-1:0]     tail;
  logic [IDXW-1:0]     count;
  logic [SUMW-1:0]     sum;
  req_t                req_q;
  logic [ENTW-1:0]     mem [SLOTS];
  logic [ENTW-1:0]     rd_data;
  logic [SUMW-1:0]     rem;
  logic [SUMW-1:0]     dsr;
  logic [HEIGHT_W-1:0] quo;
  logic [STEPW-1:0]    step;
  logic [IDXW-1:0]     div_n;

  logic [ID_BITS-1:0]  rd_id;
  logic [HEIGHT_W-1:0] rd_h;
  logic                full;
  logic                we;
  logic [SUMW-1:0]     sum_ins;
  logic [IDXW-1:0]     n_ins;
  logic [IDXW:0]       twice_r;
  logic                round_up;
  logic [IDXW-1:0]     occ_calc;

  function automatic logic [IDXW-1:0] adv(input logic [IDXW-1:0] i);
    adv = (i == IDXW'(SLOTS - 1)) ? '0 : i + 1'b1;
  endfunction

  assign busy    = (state != S_IDLE);
  assign rd_id   = rd_data[ENTW-1:HEIGHT_W];
  assign rd_h    = rd_data[HEIGHT_W-1:0];
  assign full    = (count == IDXW'(SLOTS - 1));
  assign we      = (state == S_READ) && (req_q.req_type == REQ_INSERT);
  assign sum_ins = sum + SUMW'(req_q.height) - (full ? SUMW'(rd_h) : '0);
  assign n_ins   = full ? count : count + 1'b1;
  assign twice_r = {rem[IDXW-1:0], 1'b0};
  assign round_up = (twice_r > {1'b0, div_n}) || ((twice_r == {1'b0, div_n}) && quo[0]);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[tail] <= {ID_BITS'(req_q.player_id), req_q.height};
    end
    if (state == S_IDLE) begin
      rd_data <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
      sum   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req_q <= req;
            state <= S_READ;
          end
        end
        S_READ: begin
          if (req_q.req_type == REQ_INSERT) begin
            tail  <= adv(tail);
            if (full) begin
              head <= adv(head);
            end
            count <= n_ins;
            sum   <= sum_ins;
            div_n <= n_ins;
            rem   <= sum_ins;
            dsr   <= SUMW'(n_ins) << (HEIGHT_W - 1);
            quo   <= '0;
            step  <= STEPW'(HEIGHT_W - 1);
            state <= S_DIV;
          end else if (count == '0) begin
            result.mean_height    <= '0;
            result.removed_id     <= '0;
            result.removed_height <= '0;
            result.empty_error    <= 1'b1;
            result.occupancy      <= '0;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            head  <= adv(head);
            count <= count - 1'b1;
            sum   <= sum - SUMW'(rd_h);
            result.mean_height    <= '0;
            result.removed_id     <= ID_W'(rd_id);
            result.removed_height <= rd_h;
            result.empty_error    <= 1'b0;
            result.occupancy      <= OCC_W'(count - 1'b1);
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (rem >= dsr) begin
            rem <= rem - dsr;
            quo <= {quo[HEIGHT_W-2:0], 1'b1};
          end else begin
            quo <= {quo[HEIGHT_W-2:0], 1'b0};
          end
          dsr <= dsr >> 1;
          if (step == '0) begin
            state <= S_ROUND;
          end else begin
            step <= step - 1'b1;
          end
        end
        S_ROUND: begin
          result.mean_height    <= quo + HEIGHT_W'(round_up);
          result.removed_id     <= '0;
          result.removed_height <= '0;
          result.empty_error    <= 1'b0;
          result.occupancy      <= OCC_W'(count);
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign occ_calc = (tail >= head) ? tail - head : tail + IDXW'(SLOTS) - head;

  `RQWM_ASSERT_NOW(a_count_range, 1'b1, count <= IDXW'(SLOTS - 1), "entry count above capacity")
  `RQWM_ASSERT_NOW(a_ptr_count, 1'b1, occ_calc == count, "head, tail and count disagree")
  `RQWM_ASSERT_NEXT(a_single_strobe, done, !done, "result strobe held for two cycles")
  `RQWM_ASSERT_NOW(a_empty_result, done && result.empty_error,
                   result.occupancy == '0 && result.mean_height == '0,
                   "empty remove reported data")

endmodule

@@ bench/ring_queue_with_window_mean_unit_tb.sv @@
`timescale 1ns / 1ps

module ring_queue_with_window_mean_unit_tb;
  import rqwm_pkg::*;

  localparam int DEPTH = SLOTS_DEF;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_ITEMS = 1525;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic done;
  result_t result;

  logic [ID_W-1:0] held_id [DEPTH];
  logic [HEIGHT_W-1:0] held_height [DEPTH];
  int head_slot = 0;
  int tail_slot = 0;
  int held_count = 0;
  result_t pending_results[$];
  int error_count = 0;
  int quiet_cycles = 0;
  bit steady_run = 1'b0;

  ring_queue_with_window_mean_unit uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .req(req),
    .busy(busy),
    .done(done),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic req_t make_req(input logic kind, input int id, input int hgt);
    req_t r;
    r.req_type = kind;
    r.player_id = id[ID_W-1:0];
    r.height = hgt[HEIGHT_W-1:0];
    return r;
  endfunction

  // Applies one request to the shadow queue and returns the result it should produce.
  function automatic result_t queue_step(input req_t r);
    result_t res;
    int slot;
    int total;
    int quot;
    int rem;
    res = '0;
    if (r.req_type == REQ_INSERT) begin
      if (held_count >= DEPTH - 1) begin
        head_slot = (head_slot + 1) % DEPTH;
        held_count--;
      end
      held_id[tail_slot] = r.player_id;
      held_height[tail_slot] = r.height;
      tail_slot = (tail_slot + 1) % DEPTH;
      held_count++;
      total = 0;
      slot = head_slot;
      for (int k = 0; k < held_count; k++) begin
        total += int'(held_height[slot]);
        slot = (slot + 1) % DEPTH;
      end
      quot = total / held_count;
      rem = total % held_count;
      if (2 * rem > held_count || (2 * rem == held_count && quot[0])) begin
        quot++;
      end
      res.mean_height = quot[HEIGHT_W-1:0];
    end else if (held_count == 0) begin
      res.empty_error = 1'b1;
    end else begin
      res.removed_id = held_id[head_slot];
      res.removed_height = held_height[head_slot];
      head_slot = (head_slot + 1) % DEPTH;
      held_count--;
    end
    res.occupancy = held_count[OCC_W-1:0];
    return res;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  function automatic void check_result(input result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %p", $time, got);
      error_count++;
    end else begin
      want = pending_results.pop_front();
      compare_field("mean_height", 32'(want.mean_height), 32'(got.mean_height));
      compare_field("removed_id", 32'(want.removed_id), 32'(got.removed_id));
      compare_field("removed_height", 32'(want.removed_height), 32'(got.removed_height));
      compare_field("empty_error", 32'(want.empty_error), 32'(got.empty_error));
      compare_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        check_result(result);
      end
      if ((start && !busy) || done) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Sends one transaction and records its predicted result once it is accepted.
  task automatic send_request(input req_t item);
    if (!steady_run && $urandom_range(99) < 31) begin
      idle_cycles($urandom_range(1, 14));
    end
    @(negedge clk);
    start <= 1'b1;
    req <= item;
    do @(posedge clk); while (busy);
    pending_results.push_back(queue_step(item));
  endtask

  task automatic drain_queue();
    idle_cycles(1);
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic check_empty_remove();
    send_request(make_req(REQ_REMOVE, 0, 0));
    send_request(make_req(REQ_REMOVE, 4095, 255));
  endtask

  task automatic check_mean_rounding();
    send_request(make_req(REQ_INSERT, 0, 1));
    send_request(make_req(REQ_INSERT, 4095, 2));
    send_request(make_req(REQ_INSERT, 2730, 3));
    repeat (3) send_request(make_req(REQ_REMOVE, 1365, 170));
    send_request(make_req(REQ_INSERT, 1365, 2));
    send_request(make_req(REQ_INSERT, 2730, 3));
    repeat (2) send_request(make_req(REQ_REMOVE, 0, 0));
  endtask

  task automatic check_overflow_wrap();
    for (int k = 0; k < 5; k++) begin
      send_request(make_req(REQ_INSERT, 4091 + k, 255));
    end
    send_request(make_req(REQ_INSERT, 0, 0));
    send_request(make_req(REQ_INSERT, 1, 0));
    repeat (6) send_request(make_req(REQ_REMOVE, 4095, 255));
  endtask

  // Insert-heavy, balanced and remove-heavy stretches keep the queue swinging between
  // full and empty.
  task automatic check_random_traffic(input int n_items);
    int insert_pct = 50;
    req_t item;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0: insert_pct = 15;
          1: insert_pct = 50;
          default: insert_pct = 85;
        endcase
      end
      steady_run = (i >= 600 && i < 800);
      item.req_type = ($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
      item.player_id = ID_W'($urandom);
      case ($urandom_range(9))
        0: item.height = '0;
        1: item.height = '1;
        default: item.height = HEIGHT_W'($urandom);
      endcase
      send_request(item);
    end
    steady_run = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    check_empty_remove();
    check_mean_rounding();
    check_overflow_wrap();
    check_random_traffic(RANDOM_ITEMS);
    drain_queue();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
